### design/spq_pkg.sv
package spq_pkg;

    localparam int DEPTH   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int PRIO_W  = 8;
    localparam int DATA_W  = 32;
    localparam int FILL_W  = 6;
    localparam int STAT_W  = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

### design/sorted_priority_queue.sv
// Sorted priority queue of DEPTH entries built as a chain of cells, cell 0
// always holding the entry with the smallest priority number; equal
// priorities leave in arrival order. Every transaction (insert or remove)
// updates all cells at once: each cell compares its own priority against the
// incoming one and either holds, loads the new entry or takes its left
// neighbor, and a remove shifts every cell one place toward cell 0. A new
// transaction is accepted every cycle; the only wait comes from the single
// output register, which stalls the input side only while its result is
// held by the downstream stall. Inserts into a full queue are dropped and
// flagged full; removes from an empty queue are flagged empty.
module sorted_priority_queue (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_op,
    input  logic [spq_pkg::PRIO_W-1:0]           i_priority_req,
    input  logic signed [spq_pkg::DATA_W-1:0]    i_payload,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [spq_pkg::STAT_W-1:0]           o_status,
    output logic                                 o_out_valid,
    output logic [spq_pkg::PRIO_W-1:0]           o_out_priority,
    output logic signed [spq_pkg::DATA_W-1:0]    o_out_payload,
    output logic [spq_pkg::FILL_W-1:0]           o_fill_count
);
    import spq_pkg::*;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [PRIO_W-1:0]        r_out_prio;
    logic [PRIO_W-1:0]        n_out_prio;
    logic signed [DATA_W-1:0] r_out_data;
    logic signed [DATA_W-1:0] n_out_data;
    logic [FILL_W-1:0]        r_fill;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_cell_ctl w_ctl;

    t_entry w_entry     [DEPTH];
    t_entry w_left      [DEPTH];
    t_entry w_right     [DEPTH];
    logic   w_keep      [DEPTH];
    logic   w_left_keep [DEPTH];

    assign o_stall  = r_valid && i_stall;
    assign w_accept = i_valid && !o_stall;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);

    assign w_ctl.ins            = w_accept && (i_op == OP_INSERT) && !w_full;
    assign w_ctl.rem            = w_accept && (i_op == OP_REMOVE) && !w_empty;
    assign w_ctl.new_entry.prio = i_priority_req;
    assign w_ctl.new_entry.data = i_payload;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign w_left_keep[gi] = 1'b1;
                assign w_left[gi]      = w_ctl.new_entry;
            end else begin : g_body
                assign w_left_keep[gi] = w_keep[gi-1];
                assign w_left[gi]      = w_entry[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_tail
                assign w_right[gi] = w_entry[gi];
            end else begin : g_inner
                assign w_right[gi] = w_entry[gi+1];
            end

            spq_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occupied  (CNT_W'(gi) < r_count),
                .i_left_keep (w_left_keep[gi]),
                .i_left      (w_left[gi]),
                .i_right     (w_right[gi]),
                .o_entry     (w_entry[gi]),
                .o_keep      (w_keep[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_out_valid = 1'b0;
        n_out_prio  = '0;
        n_out_data  = '0;
        if (i_op == OP_INSERT) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count     = r_count - CNT_W'(1);
                n_out_valid = 1'b1;
                n_out_prio  = w_entry[0].prio;
                n_out_data  = w_entry[0].data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
            r_out_prio  <= n_out_prio;
            r_out_data  <= n_out_data;
            r_fill      <= FILL_W'(n_count);
        end
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_out_valid    = r_out_valid;
    assign o_out_priority = r_out_prio;
    assign o_out_payload  = r_out_data;
    assign o_fill_count   = r_fill;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_entry[0].prio <= w_entry[1].prio))
        else $error("head cells out of order");

    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.rem |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not decrement count");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not increment count");

    a_out_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out_valid) |-> (r_status == ST_OK))
        else $error("returned entry with error status");

endmodule

### design/spq_cell.sv
module spq_cell (
    input  logic              i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,
    input  logic              i_left_keep,
    input  spq_pkg::t_entry   i_left,
    input  spq_pkg::t_entry   i_right,
    output spq_pkg::t_entry   o_entry,
    output logic              o_keep
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry stays put on insert when it is not ordered after the new one
    assign o_keep  = i_occupied && (r_entry.prio <= i_ctl.new_entry.prio);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                n_entry = i_left_keep ? i_ctl.new_entry : i_left;
            end
        end else if (i_ctl.rem) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### tb/spq_order_checker.sv
`timescale 1ns / 1ps

module spq_order_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic                              i_op,
    input  logic [spq_pkg::PRIO_W-1:0]        i_priority_req,
    input  logic signed [spq_pkg::DATA_W-1:0] i_payload,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [spq_pkg::STAT_W-1:0]        i_status,
    input  logic                              i_out_entry_valid,
    input  logic [spq_pkg::PRIO_W-1:0]        i_out_priority,
    input  logic signed [spq_pkg::DATA_W-1:0] i_out_payload,
    input  logic [spq_pkg::FILL_W-1:0]        i_fill_count,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked,
    output int                                o_inserts,
    output int                                o_full_drops,
    output int                                o_removes,
    output int                                o_empty_removes,
    output int                                o_peak_fill
);
    import spq_pkg::*;

    typedef struct packed {
        t_status                  status;
        logic                     got;
        logic [PRIO_W-1:0]        prio;
        logic signed [DATA_W-1:0] data;
        logic [FILL_W-1:0]        fill;
    } t_result;

    t_entry  held [DEPTH];
    int      held_count;
    t_result queued_results [$];
    t_result want;
    t_result fresh;

    function automatic t_result apply_op(input logic op, input t_entry e);
        t_result r;
        int      pos;
        int      k;
        r = '0;
        r.status = ST_OK;
        if (op == OP_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_count && held[pos].prio <= e.prio) pos++;
                for (k = held_count; k > pos; k--) held[k] = held[k-1];
                held[pos] = e;
                held_count++;
            end
        end else if (held_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            r.got  = 1'b1;
            r.prio = held[0].prio;
            r.data = held[0].data;
            for (k = 1; k < held_count; k++) held[k-1] = held[k];
            held_count--;
        end
        r.fill = FILL_W'(held_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            queued_results.delete();
            o_fail_count = 0;
            o_pending = 0;
            o_checked = 0;
            o_inserts = 0;
            o_full_drops = 0;
            o_removes = 0;
            o_empty_removes = 0;
            o_peak_fill = 0;
        end else begin
            // result first: a transaction accepted now cannot show up on this edge
            if (i_out_valid && !i_out_stall) begin
                if (queued_results.size() == 0) begin
                    $error("result transaction with no expectation waiting");
                    o_fail_count++;
                end else begin
                    want = queued_results.pop_front();
                    o_checked++;
                    if (i_status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_out_entry_valid !== want.got) begin
                        $error("out_valid expected %0d got %0d", want.got, i_out_entry_valid);
                        o_fail_count++;
                    end
                    if (i_out_priority !== want.prio) begin
                        $error("out_priority expected %0d got %0d", want.prio, i_out_priority);
                        o_fail_count++;
                    end
                    if (i_out_payload !== want.data) begin
                        $error("out_payload expected %0d got %0d", want.data, i_out_payload);
                        o_fail_count++;
                    end
                    if (i_fill_count !== want.fill) begin
                        $error("fill_count expected %0d got %0d", want.fill, i_fill_count);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                fresh = apply_op(i_op, {i_priority_req, i_payload});
                queued_results.push_back(fresh);
                if (i_op == OP_INSERT) begin
                    o_inserts++;
                    if (fresh.status == ST_FULL) o_full_drops++;
                end else begin
                    o_removes++;
                    if (fresh.status == ST_EMPTY) o_empty_removes++;
                end
                if (held_count > o_peak_fill) o_peak_fill = held_count;
            end
            o_pending = queued_results.size();
        end
    end

endmodule

### tb/tb_sorted_priority_queue.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
    import spq_pkg::*;

    localparam int HOLD_CYCLES = 60;
    localparam int SEGMENTS    = 15;
    localparam int SEG_ITEMS   = 100;

    logic                     i_clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     op = OP_INSERT;
    logic [PRIO_W-1:0]        prio = '0;
    logic signed [DATA_W-1:0] payload = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [STAT_W-1:0]        status;
    logic                     out_entry_valid;
    logic [PRIO_W-1:0]        out_priority;
    logic signed [DATA_W-1:0] out_payload;
    logic [FILL_W-1:0]        fill_count;

    int fail_count, pending, checked, inserts, full_drops, removes, empty_removes, peak_fill;

    bit gap_en = 1'b0;
    bit stall_en = 1'b0;
    bit hold_req = 1'b0;
    int stall_left = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    sorted_priority_queue uut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_op           (op),
        .i_priority_req (prio),
        .i_payload      (payload),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_status       (status),
        .o_out_valid    (out_entry_valid),
        .o_out_priority (out_priority),
        .o_out_payload  (out_payload),
        .o_fill_count   (fill_count)
    );

    spq_order_checker u_order_check (
        .i_clk             (i_clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_op              (op),
        .i_priority_req    (prio),
        .i_payload         (payload),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_status          (status),
        .i_out_entry_valid (out_entry_valid),
        .i_out_priority    (out_priority),
        .i_out_payload     (out_payload),
        .i_fill_count      (fill_count),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_inserts         (inserts),
        .o_full_drops      (full_drops),
        .o_removes         (removes),
        .o_empty_removes   (empty_removes),
        .o_peak_fill       (peak_fill)
    );

    task automatic send_op(input logic kind, input logic [PRIO_W-1:0] p,
                           input logic signed [DATA_W-1:0] d);
        int gap;
        gap = (gap_en && $urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        op = kind;
        prio = p;
        payload = d;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_random(input int insert_pct, input bit narrow);
        logic                     kind;
        logic [PRIO_W-1:0]        p;
        logic signed [DATA_W-1:0] d;
        kind = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        p = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom_range(0, 255));
        d = $urandom;
        send_op(kind, p, d);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_valid = 1'b0;
        wait (pending == 0);
    endtask

    // receiver side: random stall bursts plus one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall = 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (stall_left > 0) begin
                out_stall = 1'b1;
                stall_left--;
            end else if (stall_en && $urandom_range(0, 5) == 0) begin
                out_stall = 1'b1;
                stall_left = $urandom_range(0, 7);
            end else begin
                out_stall = 1'b0;
            end
        end
    end

    initial begin
        int seg;
        int n;
        int insert_pct;
        bit narrow;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        rst_n = 1'b1;

        // directed: empty remove, field extremes, ties in arrival order
        send_op(OP_REMOVE, 8'd0, 32'sd0);
        send_op(OP_INSERT, 8'd255, 32'sh7fffffff);
        send_op(OP_INSERT, 8'd0, 32'sh80000000);
        send_op(OP_INSERT, 8'd128, 32'sd0);
        send_op(OP_INSERT, 8'd5, 32'sd1);
        send_op(OP_INSERT, 8'd5, 32'sd2);
        send_op(OP_INSERT, 8'd5, 32'sd3);
        send_op(OP_INSERT, 8'd0, -32'sd1);
        send_op(OP_INSERT, 8'd255, 32'sh55555555);
        repeat (9) send_op(OP_REMOVE, 8'hff, -32'sd1);
        send_op(OP_INSERT, 8'haa, 32'shaaaaaaaa);
        send_op(OP_REMOVE, 8'd0, 32'sd0);
        send_op(OP_REMOVE, 8'd0, 32'sd0);

        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 5)
                0: insert_pct = 85;
                1: insert_pct = 50;
                2: insert_pct = 15;
                3: insert_pct = 70;
                default: insert_pct = 35;
            endcase
            narrow = (seg % 3 == 1);
            gap_en = (seg < SEGMENTS - 2) && (seg % 4 != 2);
            stall_en = (seg < SEGMENTS - 2) && (seg % 4 != 1);
            for (n = 0; n < SEG_ITEMS; n++) begin
                if (seg == 3 && n == 10) hold_req = 1'b1;
                if (seg == 6 && n == 50) wait_drained();
                send_random(insert_pct, narrow);
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("covered %0d inserts (%0d dropped on full) and %0d removes (%0d on empty)",
                 inserts, full_drops, removes, empty_removes);
        $display("deepest fill %0d of %0d, %0d results checked", peak_fill, DEPTH, checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### files.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
tb/spq_order_checker.sv
tb/tb_sorted_priority_queue.sv
